### design/cfd_pkg.sv
// shared types and constants for the cobs frame decoder
// no dependencies
`default_nettype none

package cfd_pkg;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_TRUNC = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic [7:0] FULL_CODE  = 8'd255;
  localparam logic [7:0] EMPTY_CODE = 8'd1;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } cfd_beat_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] out_byte;
    logic       frame_end;
    logic [1:0] status;
  } cfd_result_t;

endpackage

`default_nettype wire

### design/cfd_in_reg.sv
// input register stage of the cobs frame decoder
// depends on cfd_pkg
`default_nettype none

module cfd_in_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              kind,
  input  wire logic [7:0]        data_byte,
  input  wire logic              advance,
  output logic                   beat_valid,
  output cfd_pkg::cfd_beat_t     beat
);

  logic accept;

  assign in_stall = beat_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_valid <= 1'b0;
    end else if (accept) begin
      beat_valid <= 1'b1;
    end else if (advance) begin
      beat_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      beat.kind      <= kind;
      beat.data_byte <= data_byte;
    end
  end

endmodule

`default_nettype wire

### design/cfd_core.sv
// decoder state and per-beat next-state logic for the cobs frame decoder
// depends on cfd_pkg
`default_nettype none

module cfd_core (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 step,
  input  wire cfd_pkg::cfd_beat_t   beat,
  output cfd_pkg::cfd_result_t      res
);

  logic [7:0] bytes_left;
  logic [7:0] bytes_left_next;
  logic       expect_code;
  logic       expect_code_next;
  logic       group_is_full;
  logic       group_is_full_next;
  logic       zero_pending;
  logic       zero_pending_next;
  logic [7:0] held_data;
  logic [7:0] held_data_next;
  logic       held_valid;
  logic       held_valid_next;
  logic       failed;
  logic       failed_next;
  logic       saw_input;
  logic       saw_input_next;

  always_comb begin
    bytes_left_next    = bytes_left;
    expect_code_next   = expect_code;
    group_is_full_next = group_is_full;
    zero_pending_next  = zero_pending;
    held_data_next     = held_data;
    held_valid_next    = held_valid;
    failed_next        = failed;
    saw_input_next     = saw_input;
    res                = '0;

    if (step) begin
      if (beat.kind) begin
        res.valid     = 1'b1;
        res.frame_end = 1'b1;
        if (failed) begin
          res.status = cfd_pkg::ST_TRUNC;
        end else if (!saw_input) begin
          res.status = cfd_pkg::ST_EMPTY;
        end else if (!expect_code) begin
          res.status = cfd_pkg::ST_TRUNC;
        end else begin
          res.status = cfd_pkg::ST_OK;
        end
        bytes_left_next    = 8'd0;
        expect_code_next   = 1'b1;
        group_is_full_next = 1'b0;
        zero_pending_next  = 1'b0;
        held_valid_next    = 1'b0;
        failed_next        = 1'b0;
        saw_input_next     = 1'b0;
      end else begin
        saw_input_next = 1'b1;
        if (!failed) begin
          if (expect_code) begin
            if (beat.data_byte == 8'd0) begin
              failed_next       = 1'b1;
              zero_pending_next = 1'b0;
              held_valid_next   = 1'b0;
            end else begin
              // release what the previous group left behind
              if (zero_pending) begin
                res.valid    = 1'b1;
                res.out_byte = 8'd0;
              end else if (held_valid) begin
                res.valid    = 1'b1;
                res.out_byte = held_data;
              end
              held_valid_next    = 1'b0;
              bytes_left_next    = beat.data_byte - 8'd1;
              group_is_full_next = (beat.data_byte == cfd_pkg::FULL_CODE);
              zero_pending_next  = (beat.data_byte == cfd_pkg::EMPTY_CODE);
              expect_code_next   = (beat.data_byte == cfd_pkg::EMPTY_CODE);
            end
          end else begin
            bytes_left_next = bytes_left - 8'd1;
            if (bytes_left == 8'd1) begin
              expect_code_next = 1'b1;
              if (group_is_full) begin
                held_data_next  = beat.data_byte;
                held_valid_next = 1'b1;
              end else begin
                zero_pending_next = 1'b1;
                res.valid         = 1'b1;
                res.out_byte      = beat.data_byte;
              end
            end else begin
              res.valid    = 1'b1;
              res.out_byte = beat.data_byte;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left    <= 8'd0;
      expect_code   <= 1'b1;
      group_is_full <= 1'b0;
      zero_pending  <= 1'b0;
      held_valid    <= 1'b0;
      failed        <= 1'b0;
      saw_input     <= 1'b0;
    end else begin
      bytes_left    <= bytes_left_next;
      expect_code   <= expect_code_next;
      group_is_full <= group_is_full_next;
      zero_pending  <= zero_pending_next;
      held_valid    <= held_valid_next;
      failed        <= failed_next;
      saw_input     <= saw_input_next;
    end
  end

  always_ff @(posedge clk) begin
    held_data <= held_data_next;
  end

endmodule

`default_nettype wire

### design/cfd_out_reg.sv
// result register of the cobs frame decoder
// depends on cfd_pkg
`default_nettype none

module cfd_out_reg (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire cfd_pkg::cfd_result_t   res,
  input  wire logic                   out_stall,
  output logic                        out_free,
  output logic                        out_valid,
  output logic [7:0]                  out_byte,
  output logic                        frame_end,
  output logic [1:0]                  status
);

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_byte  <= res.out_byte;
      frame_end <= res.frame_end;
      status    <= res.status;
    end
  end

endmodule

`default_nettype wire

### design/cobs_frame_decoder.sv
// cobs frame decoder top level: input register, decode logic, result register
// results are decoded from the input register and held in the result register
// throughput: one beat per cycle, limited only by out_stall
// reset: synchronous rst clears both stages and returns the decoder to packet start
// depends on cfd_pkg, cfd_in_reg, cfd_core, cfd_out_reg
`default_nettype none

module cobs_frame_decoder (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       kind,
  input  wire logic [7:0] data_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            frame_end,
  output logic [1:0]      status
);

  logic                 beat_valid;
  cfd_pkg::cfd_beat_t   beat;
  cfd_pkg::cfd_result_t res;
  logic                 out_free;
  logic                 advance;

  assign advance = beat_valid && out_free;

  cfd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .data_byte  (data_byte),
    .advance    (advance),
    .beat_valid (beat_valid),
    .beat       (beat)
  );

  cfd_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .beat (beat),
    .res  (res)
  );

  cfd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .res       (res),
    .out_stall (out_stall),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_byte  (out_byte),
    .frame_end (frame_end),
    .status    (status)
  );

`ifndef SYNTHESIS
  a_end_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> out_byte == 8'd0)
    else $error("packet end result carries a nonzero byte");

  a_byte_status_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_end |-> status == cfd_pkg::ST_OK)
    else $error("byte result carries a status");

  a_stall_needs_beat: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> beat_valid && out_valid && out_stall)
    else $error("input stalled without a blocked beat");

  a_end_beat_result: assert property (@(posedge clk) disable iff (rst)
    advance && beat.kind |=> out_valid && frame_end)
    else $error("packet end beat gave no status result");
`endif

endmodule

`default_nettype wire
